[rtl/fhph_pkg.sv]
// Shared types and constants for the flow header parser / hash core.
// No dependencies; every other file in rtl/ imports this package.
package fhph_pkg;

    // Tag handling
    localparam int MAX_VLAN_TAGS = 2;
    localparam int VLAN_CNT_W    = $clog2(MAX_VLAN_TAGS + 2);

    // Record queue between parser and hash engine
    localparam int REC_QUEUE_DEPTH = 4;
    localparam int QPTR_W          = $clog2(REC_QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(REC_QUEUE_DEPTH + 1);

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNC     = 3'd1;
    localparam logic [2:0] ST_NOT_IPV4  = 3'd2;
    localparam logic [2:0] ST_BAD_IP    = 3'd3;
    localparam logic [2:0] ST_BAD_PROTO = 3'd4;

    // Ethertypes
    localparam logic [15:0] ETH_TYPE_VLAN_Q  = 16'h8100;
    localparam logic [15:0] ETH_TYPE_VLAN_AD = 16'h88A8;
    localparam logic [15:0] ETH_TYPE_IPV4    = 16'h0800;

    // IPv4 header fields
    localparam logic [3:0] IPV4_VERSION = 4'd4;
    localparam logic [3:0] IHL_MIN      = 4'd5;

    // IP protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // ICMP echo types
    localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;

    // packet_flags bits: bit3 marks ICMP
    localparam logic [3:0] FLAG_ICMP = 4'b1000;

    // Hash finalizer multiplier
    localparam logic [31:0] HASH_MULT = 32'h045d9f3b;

    // One frame byte
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
    } byte_item_t;

    // Parsed frame, before hashing
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  protocol;
        logic [3:0]  packet_flags;
        logic [15:0] frame_length;
    } frame_rec_t;

    // Final result
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  protocol;
        logic [3:0]  packet_flags;
        logic [31:0] hash_value;
        logic [15:0] frame_length;
    } result_t;

endpackage

[rtl/fhph_front.sv]
// Byte-serial header parser: Ethernet, VLAN tags, IPv4 and L4 headers.
// Emits one parsed frame record on the end-of-frame byte. Uses fhph_pkg.
module fhph_front
    import fhph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  byte_item_t item,
    output logic       rec_valid,
    output frame_rec_t rec
);

    typedef enum logic [4:0] {
        PH_ETH  = 5'b00001,
        PH_VLAN = 5'b00010,
        PH_IP   = 5'b00100,
        PH_L4   = 5'b01000,
        PH_DONE = 5'b10000
    } phase_t;

    localparam logic [15:0] ETH_LAST  = 16'd13;
    localparam logic [15:0] VLAN_LAST = 16'd3;
    localparam logic [15:0] TCP_LAST  = 16'd19;
    localparam logic [15:0] L4_LAST   = 16'd7;
    localparam logic [15:0] IP_MIN_LAST = 16'd19;

    phase_t                  phase_reg, phase_next, upd_phase;
    logic [15:0]             offset_reg, offset_next, upd_offset;
    logic [6:0]              hstart_reg, hstart_next, upd_hstart;
    logic [7:0]              ether_reg, ether_next, upd_ether;
    logic [VLAN_CNT_W-1:0]   vlan_reg, vlan_next, upd_vlan;
    logic [3:0]              hw_reg, hw_next, upd_hw;
    logic [31:0]             src_reg, src_next, upd_src;
    logic [31:0]             dst_reg, dst_next, upd_dst;
    logic [15:0]             sp_reg, sp_next, upd_sp;
    logic [15:0]             dp_reg, dp_next, upd_dp;
    logic [7:0]              proto_reg, proto_next, upd_proto;
    logic [3:0]              flags_reg, flags_next, upd_flags;
    logic [2:0]              err_reg, err_next, upd_err;

    logic [7:0]  b;
    logic [15:0] rel;
    logic [15:0] l2_last;
    logic [15:0] l4_last;
    logic [15:0] et_new;
    logic [6:0]  pos_plus1;
    logic        is_tag;
    logic        proto_known;
    logic [2:0]  status;
    logic        ok;

    assign b         = item.frame_byte;
    assign rel       = offset_reg - {9'd0, hstart_reg};
    assign pos_plus1 = offset_reg[6:0] + 7'd1;
    assign et_new    = {ether_reg, b};
    assign is_tag    = (et_new == ETH_TYPE_VLAN_Q) || (et_new == ETH_TYPE_VLAN_AD);
    assign l2_last   = (phase_reg == PH_ETH) ? ETH_LAST : VLAN_LAST;
    assign l4_last   = (proto_reg == PROTO_TCP) ? TCP_LAST : L4_LAST;
    assign proto_known = (proto_reg == PROTO_TCP) || (proto_reg == PROTO_UDP)
                      || (proto_reg == PROTO_ICMP);

    // Parse step for the current byte
    always_comb
    begin
        upd_phase  = phase_reg;
        upd_offset = offset_reg;
        upd_hstart = hstart_reg;
        upd_ether  = ether_reg;
        upd_vlan   = vlan_reg;
        upd_hw     = hw_reg;
        upd_src    = src_reg;
        upd_dst    = dst_reg;
        upd_sp     = sp_reg;
        upd_dp     = dp_reg;
        upd_proto  = proto_reg;
        upd_flags  = flags_reg;
        upd_err    = err_reg;

        if (offset_reg != 16'hFFFF)
        begin
            upd_offset = offset_reg + 16'd1;
        end

        unique case (phase_reg)
            PH_ETH, PH_VLAN:
            begin
                if (rel == l2_last - 16'd1 || rel == l2_last)
                begin
                    upd_ether = b;
                end
                if (rel == l2_last)
                begin
                    if (is_tag && vlan_reg < VLAN_CNT_W'(MAX_VLAN_TAGS))
                    begin
                        upd_vlan   = vlan_reg + VLAN_CNT_W'(1);
                        upd_phase  = PH_VLAN;
                        upd_hstart = pos_plus1;
                    end
                    else if (et_new == ETH_TYPE_IPV4)
                    begin
                        upd_phase  = PH_IP;
                        upd_hstart = pos_plus1;
                    end
                    else
                    begin
                        upd_phase = PH_DONE;
                        upd_err   = ST_NOT_IPV4;
                    end
                end
            end
            PH_IP:
            begin
                if (rel == 16'd0)
                begin
                    upd_hw = (b[7:4] == IPV4_VERSION && b[3:0] >= IHL_MIN) ? b[3:0] : 4'd0;
                end
                else if (rel == 16'd9)
                begin
                    upd_proto = b;
                end
                else if (rel >= 16'd12 && rel <= 16'd15)
                begin
                    upd_src = {src_reg[23:0], b};
                end
                else if (rel >= 16'd16 && rel <= 16'd19)
                begin
                    upd_dst = {dst_reg[23:0], b};
                end

                // header check waits for the fixed 20 bytes
                if (rel == IP_MIN_LAST && hw_reg == 4'd0)
                begin
                    upd_phase = PH_DONE;
                    upd_err   = ST_BAD_IP;
                end
                else if (rel >= IP_MIN_LAST && rel == {10'd0, hw_reg, 2'b00} - 16'd1)
                begin
                    if (proto_known)
                    begin
                        upd_phase  = PH_L4;
                        upd_hstart = pos_plus1;
                        upd_hw     = 4'd0;
                    end
                    else
                    begin
                        upd_phase = PH_DONE;
                        upd_err   = ST_BAD_PROTO;
                    end
                end
            end
            PH_L4:
            begin
                if (proto_reg == PROTO_ICMP)
                begin
                    // hw_reg flags an echo message here
                    if (rel == 16'd0)
                    begin
                        upd_flags = FLAG_ICMP;
                        upd_hw    = (b == ICMP_ECHO_REQUEST || b == ICMP_ECHO_REPLY)
                                  ? 4'd1 : 4'd0;
                    end
                    else if (hw_reg != 4'd0 && (rel == 16'd4 || rel == 16'd5))
                    begin
                        upd_sp = {sp_reg[7:0], b};
                    end
                    else if (hw_reg != 4'd0 && (rel == 16'd6 || rel == 16'd7))
                    begin
                        upd_dp = {dp_reg[7:0], b};
                    end
                end
                else
                begin
                    if (rel <= 16'd1)
                    begin
                        upd_sp = {sp_reg[7:0], b};
                    end
                    else if (rel <= 16'd3)
                    begin
                        upd_dp = {dp_reg[7:0], b};
                    end
                    else if (proto_reg == PROTO_TCP && rel == 16'd13)
                    begin
                        // SYN, RST, FIN from the TCP flag byte
                        upd_flags = {1'b0, b[0], b[2], b[1]};
                    end
                end
                if (rel == l4_last)
                begin
                    upd_phase = PH_DONE;
                    upd_err   = ST_OK;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Frame record from the updated state
    assign status = (upd_phase == PH_DONE) ? upd_err : ST_TRUNC;
    assign ok     = (status == ST_OK);

    always_comb
    begin
        rec.status         = status;
        rec.source_address = ok ? upd_src   : 32'd0;
        rec.dest_address   = ok ? upd_dst   : 32'd0;
        rec.source_port    = ok ? upd_sp    : 16'd0;
        rec.dest_port      = ok ? upd_dp    : 16'd0;
        rec.protocol       = ok ? upd_proto : 8'd0;
        rec.packet_flags   = ok ? upd_flags : 4'd0;
        rec.frame_length   = upd_offset;
    end

    assign rec_valid = accept && item.end_of_frame;

    // Next state: hold, step, or restart after the last byte
    always_comb
    begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        hstart_next = hstart_reg;
        ether_next  = ether_reg;
        vlan_next   = vlan_reg;
        hw_next     = hw_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        sp_next     = sp_reg;
        dp_next     = dp_reg;
        proto_next  = proto_reg;
        flags_next  = flags_reg;
        err_next    = err_reg;

        if (accept && item.end_of_frame)
        begin
            phase_next  = PH_ETH;
            offset_next = 16'd0;
            hstart_next = 7'd0;
            ether_next  = 8'd0;
            vlan_next   = '0;
            hw_next     = 4'd0;
            src_next    = 32'd0;
            dst_next    = 32'd0;
            sp_next     = 16'd0;
            dp_next     = 16'd0;
            proto_next  = 8'd0;
            flags_next  = 4'd0;
            err_next    = ST_OK;
        end
        else if (accept)
        begin
            phase_next  = upd_phase;
            offset_next = upd_offset;
            hstart_next = upd_hstart;
            ether_next  = upd_ether;
            vlan_next   = upd_vlan;
            hw_next     = upd_hw;
            src_next    = upd_src;
            dst_next    = upd_dst;
            sp_next     = upd_sp;
            dp_next     = upd_dp;
            proto_next  = upd_proto;
            flags_next  = upd_flags;
            err_next    = upd_err;
        end
    end

    // State registers; tuple fields must start each frame at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ETH;
            offset_reg <= 16'd0;
            hstart_reg <= 7'd0;
            ether_reg  <= 8'd0;
            vlan_reg   <= '0;
            hw_reg     <= 4'd0;
            src_reg    <= 32'd0;
            dst_reg    <= 32'd0;
            sp_reg     <= 16'd0;
            dp_reg     <= 16'd0;
            proto_reg  <= 8'd0;
            flags_reg  <= 4'd0;
            err_reg    <= ST_OK;
        end
        else
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            hstart_reg <= hstart_next;
            ether_reg  <= ether_next;
            vlan_reg   <= vlan_next;
            hw_reg     <= hw_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            sp_reg     <= sp_next;
            dp_reg     <= dp_next;
            proto_reg  <= proto_next;
            flags_reg  <= flags_next;
            err_reg    <= err_next;
        end
    end

endmodule

[rtl/fhph_queue.sv]
// Short FIFO of parsed frame records between parser and hash engine.
// Depth comes from fhph_pkg::REC_QUEUE_DEPTH.
module fhph_queue
    import fhph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  frame_rec_t wr_data,
    input  logic       rd_en,
    output frame_rec_t rd_data,
    output logic       full,
    output logic       empty
);

    frame_rec_t          slots_reg [REC_QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_wr;
    logic                do_rd;

    assign full    = (count_reg == QCNT_W'(REC_QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(REC_QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(REC_QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/fhph_back.sv]
// Hash engine: mixes the tuple, runs the two-round finalizer on one shared
// multiplier and holds the finished result. Uses fhph_pkg.
module fhph_back
    import fhph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rec_avail,
    input  frame_rec_t rec,
    output logic       rec_take,
    input  logic       pop,
    output logic       empty,
    output result_t    result
);

    typedef enum logic [3:0] {
        BK_IDLE  = 4'b0001,
        BK_MIX1  = 4'b0010,
        BK_MIX2  = 4'b0100,
        BK_WRITE = 4'b1000
    } bk_state_t;

    bk_state_t   state_reg, state_next;
    frame_rec_t  rec_reg, rec_next;
    logic [31:0] h_reg, h_next;
    result_t     out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] h_seed;
    logic [31:0] mul_a;
    logic [31:0] product;
    logic [31:0] h_final;
    logic        out_free;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [15:0] swap16(input logic [15:0] v);
        swap16 = {v[7:0], v[15:8]};
    endfunction

    // Tuple mix in host byte order
    assign h_seed = swap32(rec.source_address) ^ swap32(rec.dest_address)
                  ^ {swap16(rec.source_port), swap16(rec.dest_port)}
                  ^ {24'd0, rec.protocol};

    // Shared finalizer round
    assign mul_a   = h_reg ^ {16'd0, h_reg[31:16]};
    assign product = mul_a * HASH_MULT;
    assign h_final = h_reg ^ {16'd0, h_reg[31:16]};

    assign out_free = !out_valid_reg || pop;
    assign rec_take = (state_reg == BK_IDLE) && rec_avail;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        rec_next       = rec_reg;
        h_next         = h_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (rec_avail)
                begin
                    rec_next   = rec;
                    h_next     = h_seed;
                    state_next = BK_MIX1;
                end
            end
            BK_MIX1:
            begin
                h_next     = product;
                state_next = BK_MIX2;
            end
            BK_MIX2:
            begin
                h_next     = product;
                state_next = BK_WRITE;
            end
            BK_WRITE:
            begin
                if (out_free)
                begin
                    out_next.status         = rec_reg.status;
                    out_next.source_address = rec_reg.source_address;
                    out_next.dest_address   = rec_reg.dest_address;
                    out_next.source_port    = rec_reg.source_port;
                    out_next.dest_port      = rec_reg.dest_port;
                    out_next.protocol       = rec_reg.protocol;
                    out_next.packet_flags   = rec_reg.packet_flags;
                    out_next.hash_value     = (rec_reg.status == ST_OK) ? h_final : 32'd0;
                    out_next.frame_length   = rec_reg.frame_length;
                    out_valid_next          = 1'b1;
                    state_next              = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        h_reg   <= h_next;
        out_reg <= out_next;
    end

endmodule

[rtl/flow_header_parser_hash_core.sv]
// Flow header parser and hash core: takes one frame byte per cycle while the
// record queue is not full, gives one result per frame. A frame's record is
// queued on its last byte; the engine takes it when idle, then runs two rounds
// on its single 32x32 multiplier. A 4-entry record queue absorbs bursts of
// short frames. rst_n clears all control state; no clearing pass.
module flow_header_parser_hash_core
    import fhph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  byte_item_t item,
    output logic       empty,
    input  logic       pop,
    output result_t    result
);

    logic       accept;
    logic       rec_valid;
    frame_rec_t rec_wr;
    frame_rec_t rec_rd;
    logic       q_full;
    logic       q_empty;
    logic       rec_take;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Byte parser
    fhph_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .rec_valid (rec_valid),
        .rec       (rec_wr)
    );

    // Parsed record queue
    fhph_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_valid),
        .wr_data (rec_wr),
        .rd_en   (rec_take),
        .rd_data (rec_rd),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Hash engine and result register
    fhph_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_avail (!q_empty),
        .rec       (rec_rd),
        .rec_take  (rec_take),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    // A record is only produced on a transfer, so it always finds room
    a_rec_fits: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |-> !q_full)
        else $error("record pushed into full queue");

    // Failed frames carry no tuple and no hash
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != ST_OK) |->
            (result.hash_value == 32'd0 && result.source_address == 32'd0
             && result.packet_flags == 4'd0))
        else $error("non-zero fields on failed frame");

    // Status codes stay in their defined range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.status <= ST_BAD_PROTO))
        else $error("undefined status code");

    // The engine takes a record only when one is waiting
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rec_take |-> !q_empty)
        else $error("record taken from empty queue");

endmodule
